@@ hdl/assert_macros.svh @@
// Assertion macros for the RTL. Each check is clocked on clk and
// disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge.
`define CHECK_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("check failed: condition does not hold");

// A trigger that must be followed by a condition in the next cycle.
`define CHECK_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("check failed: condition missing one cycle later");

`else

`define CHECK_ALWAYS(lbl, cond)
`define CHECK_NEXT(lbl, trig, cond)

`endif

`endif

@@ hdl/i2cee_pkg.sv @@
`timescale 1ns / 1ps

package i2cee_pkg;

  // Field widths of the items.
  localparam int CMD_W    = 2;
  localparam int BADDR_W  = 16;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int ADDR_WIDTH_DEFAULT = 16;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BUSY  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TWO_BYTE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_WAIT   = 2'd2;

  // Configuration reset values.
  localparam logic              TWO_BYTE_RESET   = 1'b1;
  localparam logic [15:0]       LAST_ADDR_RESET  = 16'd32767;
  localparam logic [15:0]       WRITE_WAIT_RESET = 16'd4000;

  // Device select bytes.
  localparam logic [7:0] DEV_WRITE = 8'hA0;
  localparam logic [7:0] DEV_READ  = 8'hA1;

  // Segment slots of an access. Slots 4 and up differ between read and write.
  localparam logic [2:0] SLOT_START  = 3'd0;
  localparam logic [2:0] SLOT_DEV    = 3'd1;
  localparam logic [2:0] SLOT_HI     = 3'd2;
  localparam logic [2:0] SLOT_LO     = 3'd3;
  localparam logic [2:0] SLOT_FOUR   = 3'd4;
  localparam logic [2:0] SLOT_FIVE   = 3'd5;
  localparam logic [2:0] SLOT_RBYTE  = 3'd6;
  localparam logic [2:0] SLOT_RSTOP  = 3'd7;

  // Bit counter value of the acknowledge slot of a byte.
  localparam logic [3:0] ACK_BIT = 4'd8;

  typedef enum logic [1:0] {
    KIND_IDLE  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_WAIT  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    SEG_START = 2'd0,
    SEG_WBYTE = 2'd1,
    SEG_RBYTE = 2'd2,
    SEG_STOP  = 2'd3
  } seg_kind_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [BADDR_W-1:0] byte_address;
    logic [BYTE_W-1:0]  write_byte;
    logic               sda_sample;
  } tick_item_t;

  typedef struct packed {
    logic                scl_out;
    logic                sda_drive;
    logic                busy_res;
    logic                done_res;
    logic [BYTE_W-1:0]   read_byte;
    logic [STATUS_W-1:0] status;
  } result_item_t;

  typedef struct packed {
    logic        two_byte_address;
    logic [15:0] last_address;
    logic [15:0] write_wait_ticks;
  } cfg_t;

  // Segment type at a slot of a read or a write access.
  function automatic seg_kind_t seg_of(logic [2:0] slot, logic is_read);
    seg_kind_t s;
    s = SEG_WBYTE;
    case (slot)
      SLOT_START: s = SEG_START;
      SLOT_FOUR:  s = is_read ? SEG_START : SEG_WBYTE;
      SLOT_FIVE:  s = is_read ? SEG_WBYTE : SEG_STOP;
      SLOT_RBYTE: s = SEG_RBYTE;
      SLOT_RSTOP: s = SEG_STOP;
      default:    s = SEG_WBYTE;
    endcase
    return s;
  endfunction

endpackage

@@ hdl/i2cee_ifs.sv @@
`timescale 1ns / 1ps

// Channel carrying one tick item toward the master.
interface i2cee_tick_if;
  logic                           valid;
  logic                           ready;
  logic [i2cee_pkg::CMD_W-1:0]    cmd;
  logic [i2cee_pkg::BADDR_W-1:0]  byte_address;
  logic [i2cee_pkg::BYTE_W-1:0]   write_byte;
  logic                           sda_sample;

  modport source (output valid, cmd, byte_address, write_byte, sda_sample, input ready);
  modport sink   (input valid, cmd, byte_address, write_byte, sda_sample, output ready);
endinterface

// Channel carrying one result item away from the master.
interface i2cee_result_if;
  logic                            valid;
  logic                            ready;
  logic                            scl_out;
  logic                            sda_drive;
  logic                            busy_res;
  logic                            done_res;
  logic [i2cee_pkg::BYTE_W-1:0]    read_byte;
  logic [i2cee_pkg::STATUS_W-1:0]  status;

  modport source (output valid, scl_out, sda_drive, busy_res, done_res, read_byte, status,
                  input ready);
  modport sink   (input valid, scl_out, sda_drive, busy_res, done_res, read_byte, status,
                  output ready);
endinterface

@@ hdl/i2cee_in_stage.sv @@
`timescale 1ns / 1ps

module i2cee_in_stage (
  input  logic                  clk,
  input  logic                  rst,
  i2cee_tick_if.sink            tick,
  input  logic                  advance,
  output logic                  item_valid,
  output i2cee_pkg::tick_item_t item
);

  i2cee_pkg::tick_item_t held;
  logic                  valid;

  // A new item may enter when the register is empty or drains this cycle.
  assign tick.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (tick.ready) begin
      valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      held.cmd          <= tick.cmd;
      held.byte_address <= tick.byte_address;
      held.write_byte   <= tick.write_byte;
      held.sda_sample   <= tick.sda_sample;
    end
  end

  assign item_valid = valid;
  assign item       = held;

endmodule

@@ hdl/i2cee_seq.sv @@
`timescale 1ns / 1ps

module i2cee_seq #(
  parameter int ADDR_WIDTH = i2cee_pkg::ADDR_WIDTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    fire,
  input  i2cee_pkg::tick_item_t   item,
  input  i2cee_pkg::cfg_t         cfg,
  output i2cee_pkg::result_item_t result
);

  // Sequencer state.
  i2cee_pkg::kind_t       kind, kind_next;
  logic [2:0]             slot, slot_next;
  logic [3:0]             bitc, bitc_next;
  logic [1:0]             ph, ph_next;
  logic [ADDR_WIDTH-1:0]  held_address, cur_address;
  logic [7:0]             held_byte, cur_byte;
  logic                   held_two, cur_two;
  logic [7:0]             shift_in, cur_shift, shift_next;
  logic [15:0]            wait_counter, wait_next;
  logic                   scl, scl_next, sda, sda_next;
  logic [7:0]             last_read, last_read_next;

  // Working values of the current tick.
  i2cee_pkg::kind_t       cur_kind;
  logic [2:0]             cur_slot;
  logic [3:0]             cur_bitc;
  logic [1:0]             cur_ph;
  logic                   start_ok;
  logic [1:0]             status;
  logic                   is_cmd;
  logic                   in_range;
  logic                   active;
  logic                   is_read;
  i2cee_pkg::seg_kind_t   seg;
  logic [7:0]             seg_value;
  logic [15:0]            addr16;
  logic                   seg_last;
  logic                   seq_end;
  logic [2:0]             slot_after;
  logic                   done;

  // Command acceptance and range check.
  always_comb begin
    is_cmd   = (item.cmd == i2cee_pkg::CMD_READ) || (item.cmd == i2cee_pkg::CMD_WRITE);
    in_range = (item.byte_address <= cfg.last_address) &&
               ((item.byte_address >> ADDR_WIDTH) == '0);
    start_ok = 1'b0;
    status   = i2cee_pkg::STATUS_OK;
    if (is_cmd) begin
      if (kind != i2cee_pkg::KIND_IDLE) begin
        status = i2cee_pkg::STATUS_BUSY;
      end else if (!in_range) begin
        status = i2cee_pkg::STATUS_RANGE;
      end else begin
        start_ok = 1'b1;
      end
    end
  end

  // State as seen by this tick's pin action.
  always_comb begin
    if (start_ok) begin
      cur_kind    = (item.cmd == i2cee_pkg::CMD_READ) ? i2cee_pkg::KIND_READ
                                                      : i2cee_pkg::KIND_WRITE;
      cur_address = item.byte_address[ADDR_WIDTH-1:0];
      cur_byte    = item.write_byte;
      cur_two     = cfg.two_byte_address;
      cur_shift   = '0;
      cur_slot    = i2cee_pkg::SLOT_START;
      cur_bitc    = '0;
      cur_ph      = '0;
    end else begin
      cur_kind    = kind;
      cur_address = held_address;
      cur_byte    = held_byte;
      cur_two     = held_two;
      cur_shift   = shift_in;
      cur_slot    = slot;
      cur_bitc    = bitc;
      cur_ph      = ph;
    end
  end

  // Segment at the current slot and the byte it sends.
  always_comb begin
    active  = (cur_kind == i2cee_pkg::KIND_READ) || (cur_kind == i2cee_pkg::KIND_WRITE);
    is_read = (cur_kind == i2cee_pkg::KIND_READ);
    seg     = i2cee_pkg::seg_of(cur_slot, is_read);
    addr16  = 16'(cur_address);
    case (cur_slot)
      i2cee_pkg::SLOT_DEV:  seg_value = i2cee_pkg::DEV_WRITE;
      i2cee_pkg::SLOT_HI:   seg_value = addr16[15:8];
      i2cee_pkg::SLOT_LO:   seg_value = addr16[7:0];
      i2cee_pkg::SLOT_FOUR: seg_value = cur_byte;
      i2cee_pkg::SLOT_FIVE: seg_value = i2cee_pkg::DEV_READ;
      default:              seg_value = '0;
    endcase
  end

  // Pin action of this tick.
  always_comb begin
    scl_next   = scl;
    sda_next   = sda;
    shift_next = cur_shift;
    seg_last   = 1'b0;
    if (active) begin
      unique case (seg)
        i2cee_pkg::SEG_START: begin
          case (cur_ph)
            2'd0: sda_next = 1'b1;
            2'd1: scl_next = 1'b1;
            2'd2: sda_next = 1'b0;
            default: begin
              scl_next = 1'b0;
              seg_last = 1'b1;
            end
          endcase
        end
        i2cee_pkg::SEG_STOP: begin
          case (cur_ph)
            2'd0: sda_next = 1'b0;
            2'd1: scl_next = 1'b1;
            default: begin
              sda_next = 1'b1;
              seg_last = 1'b1;
            end
          endcase
        end
        default: begin
          if (cur_bitc == i2cee_pkg::ACK_BIT) begin
            // Acknowledge slot: SDA released, one clock pulse.
            case (cur_ph)
              2'd0: sda_next = 1'b1;
              2'd1: scl_next = 1'b1;
              default: begin
                scl_next = 1'b0;
                seg_last = 1'b1;
              end
            endcase
          end else if (seg == i2cee_pkg::SEG_WBYTE) begin
            case (cur_ph)
              2'd0:    sda_next = seg_value[~cur_bitc[2:0]];
              2'd1:    scl_next = 1'b1;
              default: scl_next = 1'b0;
            endcase
          end else begin
            case (cur_ph)
              2'd0: scl_next = 1'b1;
              2'd1: begin
                sda_next   = 1'b1;
                shift_next = {cur_shift[6:0], item.sda_sample};
              end
              default: scl_next = 1'b0;
            endcase
          end
        end
      endcase
    end
  end

  // Step counters and the access kind.
  always_comb begin
    if (cur_slot == i2cee_pkg::SLOT_DEV && !cur_two) begin
      slot_after = i2cee_pkg::SLOT_LO;
    end else begin
      slot_after = cur_slot + 3'd1;
    end
    seq_end = seg_last && (seg == i2cee_pkg::SEG_STOP);

    slot_next      = cur_slot;
    bitc_next      = cur_bitc;
    ph_next        = cur_ph;
    kind_next      = cur_kind;
    wait_next      = wait_counter;
    last_read_next = last_read;
    done           = 1'b0;

    if (active) begin
      if (seg_last) begin
        slot_next = seq_end ? i2cee_pkg::SLOT_START : slot_after;
        bitc_next = '0;
        ph_next   = '0;
      end else if (seg != i2cee_pkg::SEG_START && seg != i2cee_pkg::SEG_STOP &&
                   cur_ph == 2'd2) begin
        bitc_next = cur_bitc + 4'd1;
        ph_next   = '0;
      end else begin
        ph_next = cur_ph + 2'd1;
      end
    end

    unique case (cur_kind)
      i2cee_pkg::KIND_IDLE: begin
        kind_next = i2cee_pkg::KIND_IDLE;
      end
      i2cee_pkg::KIND_READ: begin
        if (seq_end) begin
          last_read_next = shift_next;
          kind_next      = i2cee_pkg::KIND_IDLE;
          done           = 1'b1;
        end
      end
      i2cee_pkg::KIND_WRITE: begin
        if (seq_end) begin
          if (cfg.write_wait_ticks == '0) begin
            kind_next = i2cee_pkg::KIND_IDLE;
            done      = 1'b1;
          end else begin
            wait_next = cfg.write_wait_ticks;
            kind_next = i2cee_pkg::KIND_WAIT;
          end
        end
      end
      default: begin
        wait_next = wait_counter - 16'd1;
        if (wait_next == '0) begin
          kind_next = i2cee_pkg::KIND_IDLE;
          done      = 1'b1;
        end
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      kind      <= i2cee_pkg::KIND_IDLE;
      slot      <= i2cee_pkg::SLOT_START;
      bitc      <= '0;
      ph        <= '0;
      scl       <= 1'b1;
      sda       <= 1'b1;
      last_read <= '0;
      wait_counter <= '0;
    end else if (fire) begin
      kind      <= kind_next;
      slot      <= slot_next;
      bitc      <= bitc_next;
      ph        <= ph_next;
      scl       <= scl_next;
      sda       <= sda_next;
      last_read <= last_read_next;
      wait_counter <= wait_next;
    end
  end

  // Held request and read shift register.
  always_ff @(posedge clk) begin
    if (fire) begin
      held_address <= cur_address;
      held_byte    <= cur_byte;
      held_two     <= cur_two;
      shift_in     <= shift_next;
    end
  end

  always_comb begin
    result.scl_out   = scl_next;
    result.sda_drive = sda_next;
    result.busy_res  = (kind_next != i2cee_pkg::KIND_IDLE);
    result.done_res  = done;
    result.read_byte = last_read_next;
    result.status    = status;
  end

endmodule

@@ hdl/i2cee_out_stage.sv @@
`timescale 1ns / 1ps

module i2cee_out_stage (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  i2cee_pkg::result_item_t item,
  output logic                    can_load,
  i2cee_result_if.source          result
);

  i2cee_pkg::result_item_t held;
  logic                    valid;

  // The register takes a new item when empty or being read this cycle.
  assign can_load = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= item;
    end
  end

  assign result.valid     = valid;
  assign result.scl_out   = held.scl_out;
  assign result.sda_drive = held.sda_drive;
  assign result.busy_res  = held.busy_res;
  assign result.done_res  = held.done_res;
  assign result.read_byte = held.read_byte;
  assign result.status    = held.status;

endmodule

@@ hdl/i2c_eeprom_byte_access_master.sv @@
`timescale 1ns / 1ps
// Channel   Role    Payload
// tick      sink    cmd, byte_address, write_byte, sda_sample
// result    source  scl_out, sda_drive, busy_res, done_res, read_byte, status
// cfg       write   cfg_write, cfg_index, cfg_data
//
// One item per clock while results are taken: each tick passes an input
// register, the sequencer logic and a result register.
// Throughput is set by the sequencer update, which handles one tick a cycle.
// Reset is synchronous; it idles the bus with SCL and SDA released high.
// A stalled result holds the pipeline; no item is dropped or repeated.

`include "assert_macros.svh"

module i2c_eeprom_byte_access_master #(
  parameter int ADDR_WIDTH = i2cee_pkg::ADDR_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  i2cee_tick_if.sink                        tick,
  i2cee_result_if.source                    result,
  input  logic                              cfg_write,
  input  logic [i2cee_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2cee_pkg::CFG_DATA_W-1:0]  cfg_data
);

  i2cee_pkg::cfg_t         cfg;
  i2cee_pkg::tick_item_t   item;
  i2cee_pkg::result_item_t res_item;
  logic                    item_valid;
  logic                    can_load;
  logic                    fire;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.two_byte_address <= i2cee_pkg::TWO_BYTE_RESET;
      cfg.last_address     <= i2cee_pkg::LAST_ADDR_RESET;
      cfg.write_wait_ticks <= i2cee_pkg::WRITE_WAIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        i2cee_pkg::REG_TWO_BYTE:     cfg.two_byte_address <= cfg_data[0];
        i2cee_pkg::REG_LAST_ADDRESS: cfg.last_address     <= cfg_data;
        i2cee_pkg::REG_WRITE_WAIT:   cfg.write_wait_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // A tick is processed when it is held and the result register can take it.
  assign fire = item_valid && can_load;

  i2cee_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick),
    .advance    (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  i2cee_seq #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .cfg    (cfg),
    .result (res_item)
  );

  i2cee_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .item     (res_item),
    .can_load (can_load),
    .result   (result)
  );

  // An accepted tick is held in the input register on the next cycle.
  `CHECK_NEXT(a_tick_held, tick.valid && tick.ready, item_valid)
  // A processed tick always leaves a result waiting.
  `CHECK_NEXT(a_result_loaded, fire, result.valid)
  // A completing access never reports itself busy.
  `CHECK_ALWAYS(a_done_not_busy, !(fire && res_item.done_res && res_item.busy_res))
  // A held tick that cannot drain stays held.
  `CHECK_NEXT(a_stall_holds, item_valid && !fire, item_valid)

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import i2cee_pkg::*;

  localparam int ADDR_W        = ADDR_WIDTH_DEFAULT;
  localparam int PHASE_ITEMS   = 100;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int MAX_PRINTS    = 40;

  // Pin sequence lengths in ticks, and the position of the acknowledge slot
  // within a byte.
  localparam int START_TICKS = 4;
  localparam int STOP_TICKS  = 3;
  localparam int BYTE_TICKS  = 27;
  localparam int ACK_POS     = 24;

  // Command code that the block treats as no command.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef enum logic [2:0] {
    PIN_SDA0, PIN_SDA1, PIN_SCL0, PIN_SCL1, PIN_SAMPLE
  } pin_op_t;

  typedef enum logic [1:0] {FILL_LOW, FILL_HIGH, FILL_RANDOM} fill_t;
  typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    tick_item_t               item;
    fill_t                    fill;
    logic                     run_out;
    logic                     typed;
    result_item_t             want;
    logic [CFG_IDX_W-1:0]     reg_idx;
    logic [CFG_DATA_W-1:0]    reg_val;
  } dir_row_t;

  // Results that can be written down directly.
  localparam result_item_t QUIET_OK    = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, STATUS_OK};
  localparam result_item_t QUIET_RANGE = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, STATUS_RANGE};
  localparam result_item_t START_OK    = '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, STATUS_OK};
  localparam result_item_t START_BUSY  = '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, STATUS_BUSY};

  localparam int N_ROWS = 22;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  i2cee_tick_if   tick_ch();
  i2cee_result_if result_ch();

  i2c_eeprom_byte_access_master #(.ADDR_WIDTH(ADDR_W)) u_top (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the master's registers and sequencer state.
  cfg_t         cfg;
  kind_t        m_kind;
  logic [7:0]   m_step;
  logic [15:0]  m_addr;
  logic [7:0]   m_wbyte;
  logic [7:0]   m_shift;
  logic [7:0]   m_last_read;
  logic [15:0]  m_wait;
  logic         m_scl;
  logic         m_sda;
  logic         m_two;

  result_item_t pin_results_q[$];

  int errors;
  int n_ticks;
  int n_checked;
  int n_reads;
  int n_writes;
  int n_range;
  int n_busy;
  int n_reg_writes;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int phase_no;
  bit hold_done;

  dir_row_t dir_rows [N_ROWS];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("i2c_eeprom_byte_access_master: mismatch");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("result %0d: %s got %0h expected %0h", n_checked, what, got, want);
  endtask

  // Advances the shadow master by one tick and returns the pin levels and
  // flags that the block must report for it.
  function automatic result_item_t step_master(tick_item_t it);
    result_item_t r;
    seg_kind_t    seg_list [8];
    logic [7:0]   seg_val [8];
    int           n_segs;
    int           pos;
    int           len;
    int           bit_no;
    int           ph;
    bit           found;
    bit           last_action;
    pin_op_t      op;
    r = '0;
    r.status = STATUS_OK;

    // A request is taken only while idle and inside the address limit.
    if (it.cmd == CMD_READ || it.cmd == CMD_WRITE) begin
      if (m_kind != KIND_IDLE) begin
        r.status = STATUS_BUSY;
        n_busy++;
      end else if (it.byte_address > cfg.last_address ||
                   (32'(it.byte_address) >> ADDR_W) != 0) begin
        r.status = STATUS_RANGE;
        n_range++;
      end else begin
        m_kind  = (it.cmd == CMD_READ) ? KIND_READ : KIND_WRITE;
        m_addr  = it.byte_address;
        m_wbyte = it.write_byte;
        m_two   = cfg.two_byte_address;
        m_shift = '0;
        m_step  = '0;
      end
    end

    if (m_kind == KIND_WAIT) begin
      m_wait = m_wait - 16'd1;
      if (m_wait == 16'd0) begin
        m_kind = KIND_IDLE;
        r.done_res = 1'b1;
        n_writes++;
      end
    end else if (m_kind != KIND_IDLE) begin
      // Lay out the segments of the running access.
      seg_list[0] = SEG_START;
      seg_val[0]  = 8'h00;
      seg_list[1] = SEG_WBYTE;
      seg_val[1]  = DEV_WRITE;
      n_segs = 2;
      if (m_two) begin
        seg_list[n_segs] = SEG_WBYTE;
        seg_val[n_segs]  = m_addr[15:8];
        n_segs++;
      end
      seg_list[n_segs] = SEG_WBYTE;
      seg_val[n_segs]  = m_addr[7:0];
      n_segs++;
      if (m_kind == KIND_READ) begin
        seg_list[n_segs]     = SEG_START;
        seg_val[n_segs]      = 8'h00;
        seg_list[n_segs + 1] = SEG_WBYTE;
        seg_val[n_segs + 1]  = DEV_READ;
        seg_list[n_segs + 2] = SEG_RBYTE;
        seg_val[n_segs + 2]  = 8'h00;
        n_segs += 3;
      end else begin
        seg_list[n_segs] = SEG_WBYTE;
        seg_val[n_segs]  = m_wbyte;
        n_segs++;
      end
      seg_list[n_segs] = SEG_STOP;
      seg_val[n_segs]  = 8'h00;
      n_segs++;

      // Find the segment holding the current step and apply its pin action.
      pos = m_step;
      found = 1'b0;
      last_action = 1'b1;
      for (int k = 0; k < n_segs; k++) begin
        if (!found) begin
          len = (seg_list[k] == SEG_START) ? START_TICKS :
                (seg_list[k] == SEG_STOP)  ? STOP_TICKS  : BYTE_TICKS;
          if (pos < len) begin
            found = 1'b1;
            bit_no = pos / 3;
            ph = pos % 3;
            case (seg_list[k])
              SEG_START: op = (pos == 0) ? PIN_SDA1 : (pos == 1) ? PIN_SCL1 :
                              (pos == 2) ? PIN_SDA0 : PIN_SCL0;
              SEG_STOP:  op = (pos == 0) ? PIN_SDA0 : (pos == 1) ? PIN_SCL1 : PIN_SDA1;
              default: begin
                if (pos == ACK_POS) op = PIN_SDA1;
                else if (pos == ACK_POS + 1) op = PIN_SCL1;
                else if (pos == ACK_POS + 2) op = PIN_SCL0;
                else if (seg_list[k] == SEG_WBYTE)
                  op = (ph == 0) ? (seg_val[k][7 - bit_no] ? PIN_SDA1 : PIN_SDA0) :
                       (ph == 1) ? PIN_SCL1 : PIN_SCL0;
                else
                  op = (ph == 0) ? PIN_SCL1 : (ph == 1) ? PIN_SAMPLE : PIN_SCL0;
              end
            endcase
            case (op)
              PIN_SDA0: m_sda = 1'b0;
              PIN_SDA1: m_sda = 1'b1;
              PIN_SCL0: m_scl = 1'b0;
              PIN_SCL1: m_scl = 1'b1;
              default: begin
                m_sda = 1'b1;
                m_shift = {m_shift[6:0], it.sda_sample};
              end
            endcase
            m_step = m_step + 8'd1;
            last_action = (k == n_segs - 1) && (pos == len - 1);
          end else begin
            pos -= len;
          end
        end
      end

      // End of the pin sequence: finish a read, or finish or park a write.
      if (last_action) begin
        m_step = '0;
        if (m_kind == KIND_READ) begin
          m_last_read = m_shift;
          m_kind = KIND_IDLE;
          r.done_res = 1'b1;
          n_reads++;
        end else if (cfg.write_wait_ticks == 16'd0) begin
          m_kind = KIND_IDLE;
          r.done_res = 1'b1;
          n_writes++;
        end else begin
          m_wait = cfg.write_wait_ticks;
          m_kind = KIND_WAIT;
        end
      end
    end

    r.scl_out   = m_scl;
    r.sda_drive = m_sda;
    r.busy_res  = (m_kind != KIND_IDLE);
    r.read_byte = m_last_read;
    return r;
  endfunction

  // Random tick: requests are mostly issued while idle, with a few refused
  // ones and spare codes mixed in as noise.
  function automatic tick_item_t random_tick();
    tick_item_t  it;
    logic [15:0] top;
    int          roll;
    it.cmd          = CMD_NONE;
    it.byte_address = 16'($urandom);
    it.write_byte   = 8'($urandom);
    it.sda_sample   = 1'($urandom_range(0, 1));
    top = cfg.last_address;
    if (ADDR_W < 16 && 32'(top) >= (32'd1 << ADDR_W))
      top = 16'((32'd1 << ADDR_W) - 1);
    roll = $urandom_range(0, 99);
    if (m_kind == KIND_IDLE) begin
      if (roll < 35) begin
        it.cmd = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
        case ($urandom_range(0, 9))
          0: it.byte_address = 16'h0000;
          1: it.byte_address = top;
          2, 3: begin
            if (top != 16'hFFFF)
              it.byte_address = 16'($urandom_range(32'(top) + 1, 65535));
            else
              it.byte_address = 16'($urandom_range(0, 65535));
          end
          default: it.byte_address = 16'($urandom_range(0, 32'(top)));
        endcase
      end else if (roll < 40) begin
        it.cmd = CMD_SPARE;
      end
    end else if (roll < 4) begin
      it.cmd = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
    end else if (roll < 6) begin
      it.cmd = CMD_SPARE;
    end
    return it;
  endfunction

  function automatic dir_row_t tick_row(logic [CMD_W-1:0] cmd, logic [15:0] addr,
                                        logic [7:0] wbyte, logic sda, fill_t fill,
                                        logic run_out, logic typed, result_item_t want);
    dir_row_t row;
    row = '0;
    row.kind    = ROW_TICK;
    row.item    = '{cmd, addr, wbyte, sda};
    row.fill    = fill;
    row.run_out = run_out;
    row.typed   = typed;
    row.want    = want;
    return row;
  endfunction

  function automatic dir_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    dir_row_t row;
    row = '0;
    row.kind    = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  // Offers one tick item, waits for it to be taken and queues what it must
  // produce.
  task automatic send_tick(tick_item_t it, logic use_want = 1'b0,
                           result_item_t want = '0);
    result_item_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid        <= 1'b1;
    tick_ch.cmd          <= it.cmd;
    tick_ch.byte_address <= it.byte_address;
    tick_ch.write_byte   <= it.write_byte;
    tick_ch.sda_sample   <= it.sda_sample;
    do @(posedge clk); while (!tick_ch.ready);
    pred = step_master(it);
    pin_results_q.push_back(use_want ? want : pred);
    n_ticks++;
  endtask

  // Feeds plain ticks until the running access and its write wait are over.
  task automatic run_to_idle(fill_t fill);
    tick_item_t it;
    while (m_kind != KIND_IDLE) begin
      it.cmd          = CMD_NONE;
      it.byte_address = 16'($urandom);
      it.write_byte   = 8'($urandom);
      it.sda_sample   = (fill == FILL_LOW)  ? 1'b0 :
                        (fill == FILL_HIGH) ? 1'b1 : 1'($urandom_range(0, 1));
      send_tick(it);
    end
  endtask

  // Stops offering items and lets every outstanding result come out.
  task automatic drain_pipeline();
    tick_ch.valid <= 1'b0;
    while (pin_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TWO_BYTE:     cfg.two_byte_address = val[0];
      REG_LAST_ADDRESS: cfg.last_address     = val;
      REG_WRITE_WAIT:   cfg.write_wait_ticks = val;
      default: ;
    endcase
    n_reg_writes++;
  endtask

  // Result side: random back-pressure, one long hold-off in the last phase,
  // and a field-by-field check of every result item taken.
  initial begin
    result_item_t got;
    result_item_t want;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
        got = {result_ch.scl_out, result_ch.sda_drive, result_ch.busy_res,
               result_ch.done_res, result_ch.read_byte, result_ch.status};
        if (pin_results_q.size() == 0) begin
          report_mismatch("result with nothing pending", 16'(got), 16'h0);
        end else begin
          want = pin_results_q.pop_front();
          n_checked++;
          if (got.scl_out !== want.scl_out)
            report_mismatch("scl_out", 16'(got.scl_out), 16'(want.scl_out));
          if (got.sda_drive !== want.sda_drive)
            report_mismatch("sda_drive", 16'(got.sda_drive), 16'(want.sda_drive));
          if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", 16'(got.busy_res), 16'(want.busy_res));
          if (got.done_res !== want.done_res)
            report_mismatch("done_res", 16'(got.done_res), 16'(want.done_res));
          if (got.read_byte !== want.read_byte)
            report_mismatch("read_byte", 16'(got.read_byte), 16'(want.read_byte));
          if (got.status !== want.status)
            report_mismatch("status", 16'(got.status), 16'(want.status));
        end
      end
      if (phase_no == 2 && !hold_done) begin
        hold_done = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Main sequence: reset, directed table, three random phases.
  initial begin
    dir_row_t   row;
    int send_pct [3];
    int recv_pct [3];
    send_pct = '{27, 80, 0};
    recv_pct = '{80, 27, 0};

    rst                  <= 1'b1;
    cfg_write            <= 1'b0;
    cfg_index            <= '0;
    cfg_data             <= '0;
    tick_ch.valid        <= 1'b0;
    tick_ch.cmd          <= CMD_NONE;
    tick_ch.byte_address <= '0;
    tick_ch.write_byte   <= '0;
    tick_ch.sda_sample   <= 1'b0;

    cfg         = '{TWO_BYTE_RESET, LAST_ADDR_RESET, WRITE_WAIT_RESET};
    m_kind      = KIND_IDLE;
    m_step      = '0;
    m_addr      = '0;
    m_wbyte     = '0;
    m_shift     = '0;
    m_last_read = '0;
    m_wait      = '0;
    m_scl       = 1'b1;
    m_sda       = 1'b1;
    m_two       = 1'b0;
    phase_no    = -1;
    send_idle_pct = send_pct[0];
    recv_idle_pct = recv_pct[0];

    dir_rows = '{
      tick_row(CMD_NONE,  16'h0000, 8'h00, 1'b1, FILL_RANDOM, 1'b0, 1'b1, QUIET_OK),
      tick_row(CMD_SPARE, 16'hFFFF, 8'hFF, 1'b1, FILL_RANDOM, 1'b0, 1'b1, QUIET_OK),
      tick_row(CMD_READ,  16'h8000, 8'h00, 1'b0, FILL_RANDOM, 1'b0, 1'b1, QUIET_RANGE),
      tick_row(CMD_WRITE, 16'hFFFF, 8'hFF, 1'b1, FILL_RANDOM, 1'b0, 1'b1, QUIET_RANGE),
      tick_row(CMD_WRITE, 16'h0000, 8'hFF, 1'b0, FILL_RANDOM, 1'b0, 1'b1, START_OK),
      tick_row(CMD_READ,  16'h0001, 8'h00, 1'b1, FILL_RANDOM, 1'b0, 1'b1, START_BUSY),
      // Register changes while a write is still out on the bus.
      reg_row(REG_WRITE_WAIT, 16'd3),
      reg_row(REG_TWO_BYTE, 16'd0),
      tick_row(CMD_NONE,  16'h5555, 8'hAA, 1'b0, FILL_RANDOM, 1'b1, 1'b0, QUIET_OK),
      tick_row(CMD_READ,  16'h7FFF, 8'h00, 1'b1, FILL_HIGH,   1'b1, 1'b0, QUIET_OK),
      reg_row(REG_TWO_BYTE, 16'd1),
      reg_row(REG_LAST_ADDRESS, 16'hFFFF),
      reg_row(REG_WRITE_WAIT, 16'd0),
      tick_row(CMD_WRITE, 16'hFFFF, 8'h00, 1'b0, FILL_LOW,    1'b1, 1'b0, QUIET_OK),
      tick_row(CMD_READ,  16'hFFFF, 8'hFF, 1'b0, FILL_LOW,    1'b1, 1'b0, QUIET_OK),
      reg_row(REG_LAST_ADDRESS, 16'h0000),
      tick_row(CMD_WRITE, 16'h0001, 8'hFF, 1'b1, FILL_RANDOM, 1'b0, 1'b1, QUIET_RANGE),
      tick_row(CMD_WRITE, 16'h0000, 8'hA5, 1'b1, FILL_RANDOM, 1'b1, 1'b0, QUIET_OK),
      reg_row(REG_LAST_ADDRESS, 16'h7FFF),
      reg_row(REG_WRITE_WAIT, 16'd1),
      tick_row(CMD_READ,  16'h1234, 8'h00, 1'b1, FILL_RANDOM, 1'b1, 1'b0, QUIET_OK),
      tick_row(CMD_WRITE, 16'h7FFF, 8'h5A, 1'b0, FILL_RANDOM, 1'b1, 1'b0, QUIET_OK)
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    for (int i = 0; i < N_ROWS; i++) begin
      row = dir_rows[i];
      if (row.kind == ROW_REG) begin
        drain_pipeline();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        send_tick(row.item, row.typed, row.want);
        if (row.run_out) run_to_idle(row.fill);
      end
    end

    // Random phases, each with its own idle mix and register settings.
    for (int p = 0; p < 3; p++) begin
      drain_pipeline();
      send_idle_pct = send_pct[p];
      recv_idle_pct = recv_pct[p];
      case (p)
        0: begin
          write_reg(REG_TWO_BYTE, 16'd1);
          write_reg(REG_LAST_ADDRESS, 16'($urandom_range(4096, 65534)));
          write_reg(REG_WRITE_WAIT, 16'($urandom_range(1, 6)));
        end
        1: begin
          write_reg(REG_TWO_BYTE, 16'd0);
          write_reg(REG_LAST_ADDRESS, 16'hFFFF);
          write_reg(REG_WRITE_WAIT, 16'd0);
        end
        default: begin
          write_reg(REG_TWO_BYTE, 16'($urandom_range(0, 1)));
          write_reg(REG_LAST_ADDRESS, 16'($urandom_range(256, 65535)));
          write_reg(REG_WRITE_WAIT, 16'($urandom_range(0, 6)));
        end
      endcase
      phase_no = p;
      repeat (PHASE_ITEMS) send_tick(random_tick());
    end

    // Let the last access finish before closing the run.
    run_to_idle(FILL_RANDOM);
    drain_pipeline();

    $display("Ran %0d ticks: %0d reads and %0d writes finished, %0d requests out of range,",
             n_ticks, n_reads, n_writes, n_range);
    $display("%0d refused while busy, %0d register writes, %0d-cycle result hold-off.",
             n_busy, n_reg_writes, HOLD_CYCLES);
    if (errors == 0) begin
      $display("i2c_eeprom_byte_access_master: match");
    end else begin
      $display("i2c_eeprom_byte_access_master: mismatch");
    end
    $finish;
  end

endmodule
